// ----- src/lbbs_pkg.sv -----
// Shared types and constants for the LED/buzzer blink sequencer.
package lbbs_pkg;

    // Operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // Channel numbers
    localparam logic [2:0] CH_BUZ   = 3'd0;
    localparam logic [2:0] CH_RED   = 3'd1;
    localparam logic [2:0] CH_GREEN = 3'd2;
    localparam logic [2:0] CH_WHITE = 3'd3;
    localparam logic [2:0] CH_COOL1 = 3'd4;
    localparam logic [2:0] CH_COOL2 = 3'd5;

    // Mode codes
    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_ON      = 3'd1;
    localparam logic [2:0] MODE_SHORT   = 3'd2;
    localparam logic [2:0] MODE_LONG    = 3'd3;
    localparam logic [2:0] MODE_MEANDER = 3'd4;

    // Output pattern bit positions
    localparam int BIT_COOL1 = 0;
    localparam int BIT_COOL2 = 1;
    localparam int BIT_BUZ   = 2;
    localparam int BIT_RED   = 3;
    localparam int BIT_GREEN = 6;
    localparam int BIT_WHITE = 7;

    // Configuration register indexes
    localparam logic [1:0] REG_SOUND_ENABLE  = 2'd0;
    localparam logic [1:0] REG_SHORT_TICKS   = 2'd1;
    localparam logic [1:0] REG_LONG_TICKS    = 2'd2;
    localparam logic [1:0] REG_MEANDER_TICKS = 2'd3;

    // Configuration reset values
    localparam logic       RST_SOUND_ENABLE  = 1'b1;
    localparam logic [7:0] RST_SHORT_TICKS   = 8'd5;
    localparam logic [7:0] RST_LONG_TICKS    = 8'd25;
    localparam logic [7:0] RST_MEANDER_TICKS = 8'd10;

    typedef struct packed {
        logic       operation;
        logic [2:0] channel;
        logic [2:0] mode_code;
    } t_in;

    typedef struct packed {
        logic [7:0] pattern;
        logic       shifted;
    } t_out;

    typedef struct packed {
        logic       sound_enable;
        logic [7:0] short_ticks;
        logic [7:0] long_ticks;
        logic [7:0] meander_ticks;
    } t_cfg;

endpackage

// ----- src/led_buzzer_blink_sequencer.sv -----
// Top level of the LED/buzzer blink sequencer: input register, channels, result register.
//
// Usage:
//   Input channel (i_valid/o_ready, i_data): each transaction is either a tick of the
//   blink clock or a mode set for one channel (buzzer, three lamps, two cooling bits).
//   Output channel (o_valid/i_ready, o_data): exactly one result per input transaction,
//   the 8-bit output pattern and a flag telling whether the pattern was strobed out.
//   Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data): writes
//   sound_enable, short_ticks, long_ticks, meander_ticks; always ready. Write only
//   while no transaction is in flight.
// Timing:
//   The item is captured in the input register, then one pass of combinational channel
//   logic loads the result register, which drives o_valid. Throughput is one item per
//   cycle while the receiver takes results; the channel state is updated in the same
//   cycle the result register loads, so each item sees the state left by the one before.
// Reset (synchronous, active low) turns every channel off, clears timers and pattern,
// and loads the configuration defaults. When the receiver stalls, the result is held,
// one more item waits in the input register, and then o_ready drops.
module led_buzzer_blink_sequencer #(
    parameter int TIMER_WIDTH = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lbbs_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output lbbs_pkg::t_out o_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [7:0]     i_cfg_data
);

    lbbs_pkg::t_cfg cfg;
    lbbs_pkg::t_in  r_in;
    logic           r_in_valid;
    logic           r_out_valid;
    logic [7:0]     r_out_bits, n_out_bits;
    logic           r_shifted,  n_shifted;
    logic           advance;
    logic           is_tick;
    logic [2:0]     mode;
    logic [3:0]     ch_write;
    logic [3:0]     on_next;

    lbbs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Handshake: input register moves on when the result register is free or drained
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
    end

    // Decode of the held item
    assign is_tick = (r_in.operation == lbbs_pkg::OP_TICK);
    assign mode    = (r_in.mode_code > lbbs_pkg::MODE_MEANDER) ? lbbs_pkg::MODE_OFF
                                                             : r_in.mode_code;
    assign ch_write[0] = !is_tick && (r_in.channel == lbbs_pkg::CH_BUZ);
    assign ch_write[1] = !is_tick && (r_in.channel == lbbs_pkg::CH_RED);
    assign ch_write[2] = !is_tick && (r_in.channel == lbbs_pkg::CH_GREEN);
    assign ch_write[3] = !is_tick && (r_in.channel == lbbs_pkg::CH_WHITE);

    // Buzzer and three lamps
    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_chan
            lbbs_chan #(
                .TIMER_WIDTH (TIMER_WIDTH),
                .IS_BUZ      (g == 0)
            ) u_chan (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_advance (advance),
                .i_tick    (is_tick),
                .i_write   (ch_write[g]),
                .i_mode    (mode),
                .i_cfg     (cfg),
                .o_on_next (on_next[g])
            );
        end
    endgenerate

    // Pattern update and strobe flag
    always_comb begin
        n_out_bits = r_out_bits;
        n_shifted  = 1'b0;
        if (is_tick) begin
            if (cfg.sound_enable) begin
                n_out_bits[lbbs_pkg::BIT_BUZ] = on_next[0];
            end
            n_out_bits[lbbs_pkg::BIT_RED]   = on_next[1];
            n_out_bits[lbbs_pkg::BIT_GREEN] = on_next[2];
            n_out_bits[lbbs_pkg::BIT_WHITE] = on_next[3];
            n_shifted = 1'b1;
        end else begin
            case (r_in.channel)
                lbbs_pkg::CH_BUZ: begin
                    if (cfg.sound_enable) begin
                        n_out_bits[lbbs_pkg::BIT_BUZ] = on_next[0];
                        n_shifted = 1'b1;
                    end
                end
                lbbs_pkg::CH_RED: begin
                    n_out_bits[lbbs_pkg::BIT_RED] = on_next[1];
                    n_shifted = 1'b1;
                end
                lbbs_pkg::CH_GREEN: begin
                    n_out_bits[lbbs_pkg::BIT_GREEN] = on_next[2];
                    n_shifted = 1'b1;
                end
                lbbs_pkg::CH_WHITE: begin
                    n_out_bits[lbbs_pkg::BIT_WHITE] = on_next[3];
                    n_shifted = 1'b1;
                end
                lbbs_pkg::CH_COOL1: begin
                    n_out_bits[lbbs_pkg::BIT_COOL1] = (mode != lbbs_pkg::MODE_OFF);
                    n_shifted = 1'b1;
                end
                lbbs_pkg::CH_COOL2: begin
                    n_out_bits[lbbs_pkg::BIT_COOL2] = (mode != lbbs_pkg::MODE_OFF);
                    n_shifted = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Result register; the pattern doubles as the live output state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_bits  <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_out_bits  <= n_out_bits;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_shifted <= n_shifted;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_data.pattern = r_out_bits;
    assign o_data.shifted = r_shifted;

    // Unused pattern bits never set
    a_unused_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_bits[5:4] == 2'b00)
        else $error("pattern bits 4 and 5 set");

    // A tick always strobes the pattern
    a_tick_strobes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_tick) |=> (r_shifted && r_out_valid))
        else $error("tick result not strobed");

    // Buzzer bit frozen while sound is disabled
    a_buz_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !cfg.sound_enable) |=> $stable(r_out_bits[lbbs_pkg::BIT_BUZ]))
        else $error("buzzer bit changed with sound disabled");

    // Both stages full and stalled: no new item taken
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_ready) |-> !o_ready)
        else $error("input accepted while pipeline full");

    // Unchanged pattern when the result register does not load
    a_bits_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_out_bits))
        else $error("pattern changed without a transaction");

endmodule

// ----- src/lbbs_cfg.sv -----
// Configuration register bank of the blink sequencer.
module lbbs_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output lbbs_pkg::t_cfg    o_cfg
);

    lbbs_pkg::t_cfg r_cfg;

    // Writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sound_enable  <= lbbs_pkg::RST_SOUND_ENABLE;
            r_cfg.short_ticks   <= lbbs_pkg::RST_SHORT_TICKS;
            r_cfg.long_ticks    <= lbbs_pkg::RST_LONG_TICKS;
            r_cfg.meander_ticks <= lbbs_pkg::RST_MEANDER_TICKS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lbbs_pkg::REG_SOUND_ENABLE:  r_cfg.sound_enable  <= i_cfg_data[0];
                lbbs_pkg::REG_SHORT_TICKS:   r_cfg.short_ticks   <= i_cfg_data;
                lbbs_pkg::REG_LONG_TICKS:    r_cfg.long_ticks    <= i_cfg_data;
                lbbs_pkg::REG_MEANDER_TICKS: r_cfg.meander_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/lbbs_chan.sv -----
// One timed channel (buzzer or lamp): mode, phase timer and on state.
module lbbs_chan #(
    parameter int TIMER_WIDTH = 8,
    parameter bit IS_BUZ      = 1'b0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_advance,
    input  logic           i_tick,
    input  logic           i_write,
    input  logic [2:0]     i_mode,
    input  lbbs_pkg::t_cfg i_cfg,
    output logic           o_on_next
);

    logic [2:0]             r_mode,  n_mode;
    logic [TIMER_WIDTH-1:0] r_timer, n_timer;
    logic                   r_on,    n_on;
    logic [TIMER_WIDTH-1:0] timer_dec;
    logic [TIMER_WIDTH-1:0] ld_short, ld_long, ld_meander;

    // Phase lengths cut or widened to the timer width
    assign ld_short   = TIMER_WIDTH'(i_cfg.short_ticks);
    assign ld_long    = TIMER_WIDTH'(i_cfg.long_ticks);
    assign ld_meander = TIMER_WIDTH'(i_cfg.meander_ticks);
    assign timer_dec  = r_timer - TIMER_WIDTH'(1);

    // Next state for a tick or a mode write
    always_comb begin
        n_mode  = r_mode;
        n_timer = r_timer;
        n_on    = r_on;
        if (i_tick) begin
            case (r_mode)
                lbbs_pkg::MODE_SHORT, lbbs_pkg::MODE_LONG: begin
                    if (IS_BUZ) begin
                        // one-shot beep
                        n_on = 1'b0;
                        if (r_timer != '0) begin
                            n_timer = timer_dec;
                            if (timer_dec != '0) begin
                                n_on = 1'b1;
                            end else begin
                                n_mode = lbbs_pkg::MODE_OFF;
                            end
                        end
                    end else if (r_timer != '0) begin
                        n_timer = timer_dec;
                        if (timer_dec == '0) begin
                            if (r_on) begin
                                n_on    = 1'b0;
                                n_timer = (r_mode == lbbs_pkg::MODE_SHORT) ? ld_long : ld_short;
                            end else begin
                                n_on    = 1'b1;
                                n_timer = (r_mode == lbbs_pkg::MODE_SHORT) ? ld_short : ld_long;
                            end
                        end
                    end
                end
                lbbs_pkg::MODE_MEANDER: begin
                    if (r_timer != '0) begin
                        n_timer = timer_dec;
                        if (timer_dec == '0) begin
                            n_on    = !r_on;
                            n_timer = ld_meander;
                        end
                    end
                end
                lbbs_pkg::MODE_ON: begin
                    // steady on for lamps, silent for the buzzer
                    if (IS_BUZ) begin
                        n_on   = 1'b0;
                        n_mode = lbbs_pkg::MODE_OFF;
                    end else begin
                        n_on = 1'b1;
                    end
                end
                default: begin
                    n_on   = 1'b0;
                    n_mode = lbbs_pkg::MODE_OFF;
                end
            endcase
        end else if (i_write) begin
            n_mode = i_mode;
            case (i_mode)
                lbbs_pkg::MODE_SHORT: begin
                    n_on    = 1'b1;
                    n_timer = ld_short;
                end
                lbbs_pkg::MODE_LONG: begin
                    n_on    = 1'b1;
                    n_timer = ld_long;
                end
                lbbs_pkg::MODE_MEANDER: begin
                    n_on    = 1'b1;
                    n_timer = ld_meander;
                end
                lbbs_pkg::MODE_ON: begin
                    // lamp keeps its timer; buzzer clears it and stays silent
                    n_on = !IS_BUZ;
                    if (IS_BUZ) begin
                        n_timer = '0;
                    end
                end
                default: begin
                    n_on = 1'b0;
                    if (IS_BUZ) begin
                        n_timer = '0;
                    end
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= lbbs_pkg::MODE_OFF;
            r_timer <= '0;
            r_on    <= 1'b0;
        end else if (i_advance) begin
            r_mode  <= n_mode;
            r_timer <= n_timer;
            r_on    <= n_on;
        end
    end

    assign o_on_next = n_on;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the LED/buzzer blink sequencer: directed table, random sequences.
module testbench;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 65;
    localparam int PHASE_COUNT     = 9;
    localparam int HOLD_AFTER      = 200;
    localparam int HOLD_CYCLES     = 150;
    localparam int DRAIN_CYCLES    = 8;

    // Channel numbers and mode codes outside the named set
    localparam logic [2:0] CH_UNUSED6  = 3'd6;
    localparam logic [2:0] CH_UNUSED7  = 3'd7;
    localparam logic [2:0] MODE_BAD5   = 3'd5;
    localparam logic [2:0] MODE_BAD7   = 3'd7;

    typedef enum {RX_ALWAYS, RX_COIN, RX_THREE_OF_FOUR, RX_MOSTLY} t_rx_style;

    // One row of the directed table
    typedef struct packed {
        lbbs_pkg::t_in  item;
        logic           known;
        lbbs_pkg::t_out want;
    } t_row;

    logic           i_clk     = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    lbbs_pkg::t_in  in_data   = '0;
    logic           out_ready = 1'b0;
    logic           cfg_valid = 1'b0;
    logic [1:0]     cfg_index = lbbs_pkg::REG_SOUND_ENABLE;
    logic [7:0]     cfg_data  = 8'd0;
    logic           o_ready;
    logic           o_valid;
    lbbs_pkg::t_out o_data;
    logic           o_cfg_ready;

    // Predictor state: index 0 buzzer, 1 red, 2 green, 3 white
    lbbs_pkg::t_cfg cfg_q;
    logic [2:0]     chan_mode  [4];
    logic [7:0]     chan_timer [4];
    logic           lamp_lit   [4];
    logic [7:0]     pattern_q;

    lbbs_pkg::t_out expected_patterns [$];
    t_row           directed_rows     [$];
    int   error_count    = 0;
    int   accepted_items = 0;
    int   burst_left     = 0;
    int   cycle_count    = 0;
    bit   hold_off       = 1'b0;
    int   rx_cycle       = 0;
    t_rx_style rx_style  = RX_ALWAYS;

    led_buzzer_blink_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_ready     (o_ready),
        .i_data      (in_data),
        .o_valid     (o_valid),
        .i_ready     (out_ready),
        .o_data      (o_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Output bit of a buzzer or lamp channel
    function automatic int lamp_pos(input int idx);
        case (idx)
            0:       return lbbs_pkg::BIT_BUZ;
            1:       return lbbs_pkg::BIT_RED;
            2:       return lbbs_pkg::BIT_GREEN;
            default: return lbbs_pkg::BIT_WHITE;
        endcase
    endfunction

    // Timer value loaded when a timed mode starts
    function automatic logic [7:0] phase_load(input logic [2:0] m);
        case (m)
            lbbs_pkg::MODE_SHORT: return cfg_q.short_ticks;
            lbbs_pkg::MODE_LONG:  return cfg_q.long_ticks;
            default:              return cfg_q.meander_ticks;
        endcase
    endfunction

    // Advances the predicted state by one transaction and returns its result
    function automatic lbbs_pkg::t_out blink_step(input lbbs_pkg::t_in it);
        lbbs_pkg::t_out r;
        logic [2:0]     m;
        int             i;
        r.shifted = 1'b0;
        m = (it.mode_code > lbbs_pkg::MODE_MEANDER) ? lbbs_pkg::MODE_OFF : it.mode_code;
        if (it.operation == lbbs_pkg::OP_TICK) begin
            // buzzer: short and long are one-shot beeps
            case (chan_mode[0])
                lbbs_pkg::MODE_SHORT, lbbs_pkg::MODE_LONG: begin
                    lamp_lit[0] = 1'b0;
                    if (chan_timer[0] != 0) begin
                        chan_timer[0] = chan_timer[0] - 8'd1;
                        if (chan_timer[0] != 0) lamp_lit[0] = 1'b1;
                        else chan_mode[0] = lbbs_pkg::MODE_OFF;
                    end
                end
                lbbs_pkg::MODE_MEANDER: begin
                    if (chan_timer[0] != 0) begin
                        chan_timer[0] = chan_timer[0] - 8'd1;
                        if (chan_timer[0] == 0) begin
                            lamp_lit[0]   = ~lamp_lit[0];
                            chan_timer[0] = cfg_q.meander_ticks;
                        end
                    end
                end
                default: begin
                    lamp_lit[0]  = 1'b0;
                    chan_mode[0] = lbbs_pkg::MODE_OFF;
                end
            endcase
            if (cfg_q.sound_enable) pattern_q[lbbs_pkg::BIT_BUZ] = lamp_lit[0];
            // lamps: periodic blinking
            for (i = 1; i < 4; i++) begin
                case (chan_mode[i])
                    lbbs_pkg::MODE_SHORT, lbbs_pkg::MODE_LONG, lbbs_pkg::MODE_MEANDER: begin
                        if (chan_timer[i] != 0) begin
                            chan_timer[i] = chan_timer[i] - 8'd1;
                            if (chan_timer[i] == 0) begin
                                if (chan_mode[i] == lbbs_pkg::MODE_MEANDER) begin
                                    lamp_lit[i]   = ~lamp_lit[i];
                                    chan_timer[i] = cfg_q.meander_ticks;
                                end else if (lamp_lit[i]) begin
                                    lamp_lit[i]   = 1'b0;
                                    chan_timer[i] = (chan_mode[i] == lbbs_pkg::MODE_SHORT) ?
                                                    cfg_q.long_ticks : cfg_q.short_ticks;
                                end else begin
                                    lamp_lit[i]   = 1'b1;
                                    chan_timer[i] = (chan_mode[i] == lbbs_pkg::MODE_SHORT) ?
                                                    cfg_q.short_ticks : cfg_q.long_ticks;
                                end
                            end
                        end
                    end
                    lbbs_pkg::MODE_ON: lamp_lit[i] = 1'b1;
                    default: begin
                        lamp_lit[i]  = 1'b0;
                        chan_mode[i] = lbbs_pkg::MODE_OFF;
                    end
                endcase
                pattern_q[lamp_pos(i)] = lamp_lit[i];
            end
            r.shifted = 1'b1;
        end else if (it.channel == lbbs_pkg::CH_BUZ) begin
            chan_mode[0] = m;
            if (m == lbbs_pkg::MODE_SHORT || m == lbbs_pkg::MODE_LONG ||
                m == lbbs_pkg::MODE_MEANDER) begin
                lamp_lit[0]   = 1'b1;
                chan_timer[0] = phase_load(m);
            end else begin
                lamp_lit[0]   = 1'b0;
                chan_timer[0] = 8'd0;
            end
            if (cfg_q.sound_enable) begin
                pattern_q[lbbs_pkg::BIT_BUZ] = lamp_lit[0];
                r.shifted = 1'b1;
            end
        end else if (it.channel <= lbbs_pkg::CH_WHITE) begin
            i = int'(it.channel);
            chan_mode[i] = m;
            if (m == lbbs_pkg::MODE_SHORT || m == lbbs_pkg::MODE_LONG ||
                m == lbbs_pkg::MODE_MEANDER) begin
                lamp_lit[i]   = 1'b1;
                chan_timer[i] = phase_load(m);
            end else begin
                // on and off modes leave the timer alone
                lamp_lit[i] = (m == lbbs_pkg::MODE_ON);
            end
            pattern_q[lamp_pos(i)] = lamp_lit[i];
            r.shifted = 1'b1;
        end else if (it.channel <= lbbs_pkg::CH_COOL2) begin
            pattern_q[(it.channel == lbbs_pkg::CH_COOL1) ? lbbs_pkg::BIT_COOL1
                                                         : lbbs_pkg::BIT_COOL2]
                = (m != lbbs_pkg::MODE_OFF);
            r.shifted = 1'b1;
        end
        r.pattern = pattern_q;
        return r;
    endfunction

    task automatic add_row(input logic op, input logic [2:0] ch, input logic [2:0] m,
                           input logic known, input logic [7:0] pat, input logic sh);
        t_row row;
        row.item.operation = op;
        row.item.channel   = ch;
        row.item.mode_code = m;
        row.known          = known;
        row.want.pattern   = pat;
        row.want.shifted   = sh;
        directed_rows.push_back(row);
    endtask

    // Offers one transaction, records its expected result, then paces the sender.
    // Called at a falling edge, returns at a falling edge.
    task automatic offer(input lbbs_pkg::t_in it, input logic known,
                         input lbbs_pkg::t_out want);
        lbbs_pkg::t_out calc;
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!o_ready);
        calc = blink_step(it);
        expected_patterns.push_back(known ? want : calc);
        accepted_items++;
        @(negedge i_clk);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            lbbs_pkg::REG_SOUND_ENABLE:  cfg_q.sound_enable  = value[0];
            lbbs_pkg::REG_SHORT_TICKS:   cfg_q.short_ticks   = value;
            lbbs_pkg::REG_LONG_TICKS:    cfg_q.long_ticks    = value;
            lbbs_pkg::REG_MEANDER_TICKS: cfg_q.meander_ticks = value;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Lets every outstanding result drain, then the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_patterns.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Receiver stall pattern, with a style picked at random
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 50 == 0) rx_style = t_rx_style'($urandom_range(0, 3));
        if (hold_off) begin
            out_ready <= 1'b0;
        end else begin
            case (rx_style)
                RX_ALWAYS:        out_ready <= 1'b1;
                RX_COIN:          out_ready <= 1'($urandom_range(0, 1));
                RX_THREE_OF_FOUR: out_ready <= (rx_cycle % 4 != 0);
                default:          out_ready <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    // One long receiver hold-off so the block fills and backs up its input
    initial begin : long_hold
        int n;
        while (accepted_items < HOLD_AFTER) @(posedge i_clk);
        hold_off = 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Result checker
    always @(posedge i_clk) begin : check_result
        lbbs_pkg::t_out want;
        if (rst_n && o_valid && out_ready) begin
            if (expected_patterns.size() == 0) begin
                $error("unexpected result transaction: pattern %h shifted %b",
                       o_data.pattern, o_data.shifted);
                error_count++;
            end else begin
                want = expected_patterns.pop_front();
                if (o_data.pattern !== want.pattern) begin
                    $error("pattern mismatch: expected %h, actual %h",
                           want.pattern, o_data.pattern);
                    error_count++;
                end
                if (o_data.shifted !== want.shifted) begin
                    $error("shifted mismatch: expected %b, actual %b",
                           want.shifted, o_data.shifted);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : main
        lbbs_pkg::t_in  it;
        lbbs_pkg::t_out none;
        lbbs_pkg::t_cfg c;
        int   ph;
        int   n;
        int   k;
        none = '0;

        // predictor reset
        cfg_q.sound_enable  = lbbs_pkg::RST_SOUND_ENABLE;
        cfg_q.short_ticks   = lbbs_pkg::RST_SHORT_TICKS;
        cfg_q.long_ticks    = lbbs_pkg::RST_LONG_TICKS;
        cfg_q.meander_ticks = lbbs_pkg::RST_MEANDER_TICKS;
        for (n = 0; n < 4; n++) begin
            chan_mode[n]  = lbbs_pkg::MODE_OFF;
            chan_timer[n] = 8'd0;
            lamp_lit[n]   = 1'b0;
        end
        pattern_q = 8'd0;

        // directed table, reset configuration
        add_row(lbbs_pkg::OP_TICK, lbbs_pkg::CH_BUZ,   lbbs_pkg::MODE_OFF,  1'b1, 8'h00, 1'b1);
        add_row(lbbs_pkg::OP_SET,  lbbs_pkg::CH_COOL1, lbbs_pkg::MODE_ON,   1'b1, 8'h01, 1'b1);
        add_row(lbbs_pkg::OP_SET,  lbbs_pkg::CH_COOL2, lbbs_pkg::MODE_MEANDER,
                1'b1, 8'h03, 1'b1);
        add_row(lbbs_pkg::OP_SET,  lbbs_pkg::CH_COOL2, MODE_BAD7,           1'b1, 8'h01, 1'b1);
        add_row(lbbs_pkg::OP_SET,  CH_UNUSED6,         lbbs_pkg::MODE_ON,   1'b1, 8'h01, 1'b0);
        add_row(lbbs_pkg::OP_SET,  CH_UNUSED7,         MODE_BAD7,           1'b1, 8'h01, 1'b0);
        // buzzer on mode is silent, next tick drops it to off
        add_row(lbbs_pkg::OP_SET,  lbbs_pkg::CH_BUZ,   lbbs_pkg::MODE_ON,   1'b1, 8'h01, 1'b1);
        add_row(lbbs_pkg::OP_TICK, CH_UNUSED7,         MODE_BAD7,           1'b1, 8'h01, 1'b1);
        add_row(lbbs_pkg::OP_SET,  lbbs_pkg::CH_RED,   lbbs_pkg::MODE_SHORT,
                1'b1, 8'h09, 1'b1);
        add_row(lbbs_pkg::OP_SET,  lbbs_pkg::CH_GREEN, lbbs_pkg::MODE_LONG, 1'b1, 8'h49, 1'b1);
        add_row(lbbs_pkg::OP_SET,  lbbs_pkg::CH_WHITE, lbbs_pkg::MODE_MEANDER,
                1'b1, 8'hC9, 1'b1);
        add_row(lbbs_pkg::OP_SET,  lbbs_pkg::CH_BUZ,   lbbs_pkg::MODE_SHORT,
                1'b1, 8'hCD, 1'b1);
        for (n = 0; n < 6; n++)
            add_row(lbbs_pkg::OP_TICK, lbbs_pkg::CH_BUZ, lbbs_pkg::MODE_OFF, 1'b0, 8'h00, 1'b0);
        add_row(lbbs_pkg::OP_SET,  lbbs_pkg::CH_RED,   lbbs_pkg::MODE_ON,   1'b0, 8'h00, 1'b0);
        add_row(lbbs_pkg::OP_TICK, lbbs_pkg::CH_COOL1, lbbs_pkg::MODE_LONG, 1'b0, 8'h00, 1'b0);
        add_row(lbbs_pkg::OP_SET,  lbbs_pkg::CH_GREEN, MODE_BAD5,           1'b0, 8'h00, 1'b0);
        add_row(lbbs_pkg::OP_SET,  lbbs_pkg::CH_WHITE, lbbs_pkg::MODE_OFF,  1'b0, 8'h00, 1'b0);
        add_row(lbbs_pkg::OP_SET,  lbbs_pkg::CH_BUZ,   lbbs_pkg::MODE_MEANDER,
                1'b0, 8'h00, 1'b0);
        add_row(lbbs_pkg::OP_TICK, lbbs_pkg::CH_BUZ,   lbbs_pkg::MODE_OFF,  1'b0, 8'h00, 1'b0);
        add_row(lbbs_pkg::OP_SET,  lbbs_pkg::CH_BUZ,   lbbs_pkg::MODE_LONG, 1'b0, 8'h00, 1'b0);
        add_row(lbbs_pkg::OP_SET,  lbbs_pkg::CH_COOL1, lbbs_pkg::MODE_LONG, 1'b0, 8'h00, 1'b0);
        add_row(lbbs_pkg::OP_SET,  lbbs_pkg::CH_COOL1, lbbs_pkg::MODE_OFF,  1'b0, 8'h00, 1'b0);

        // hold reset, then release it
        repeat (3) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        for (n = 0; n < directed_rows.size(); n++)
            offer(directed_rows[n].item, directed_rows[n].known, directed_rows[n].want);

        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            // new settings only once the block is idle
            if (ph > 0) begin
                wait_idle();
                case (ph)
                    1: c = '{sound_enable: 1'b0, short_ticks: 8'd0,
                             long_ticks: 8'd0, meander_ticks: 8'd0};
                    2: c = '{sound_enable: 1'b1, short_ticks: 8'd255,
                             long_ticks: 8'd255, meander_ticks: 8'd255};
                    3: c = '{sound_enable: 1'b1, short_ticks: 8'd1,
                             long_ticks: 8'd2, meander_ticks: 8'd3};
                    4: c = '{sound_enable: 1'b0, short_ticks: 8'd2,
                             long_ticks: 8'd1, meander_ticks: 8'd3};
                    5, 7: begin
                        c.sound_enable  = (ph == 5);
                        c.short_ticks   = 8'($urandom_range(0, 255));
                        c.long_ticks    = 8'($urandom_range(0, 255));
                        c.meander_ticks = 8'($urandom_range(0, 255));
                    end
                    6: begin
                        c.sound_enable  = 1'b1;
                        c.short_ticks   = 8'($urandom_range(0, 6));
                        c.long_ticks    = 8'($urandom_range(0, 6));
                        c.meander_ticks = 8'($urandom_range(0, 6));
                    end
                    default: c = '{sound_enable: lbbs_pkg::RST_SOUND_ENABLE,
                                   short_ticks: 8'd3, long_ticks: 8'd7,
                                   meander_ticks: 8'd4};
                endcase
                write_reg(lbbs_pkg::REG_SOUND_ENABLE, {7'd0, c.sound_enable});
                write_reg(lbbs_pkg::REG_SHORT_TICKS, c.short_ticks);
                write_reg(lbbs_pkg::REG_LONG_TICKS, c.long_ticks);
                write_reg(lbbs_pkg::REG_MEANDER_TICKS, c.meander_ticks);
                cfg_valid <= 1'b0;
                @(negedge i_clk);
            end

            // a mode set followed by a run of ticks, with some noise mixed in
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                it.operation = lbbs_pkg::OP_SET;
                it.channel   = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                           : 3'($urandom_range(0, 5));
                it.mode_code = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                           : 3'($urandom_range(0, 4));
                if ($urandom_range(0, 7) == 0) it.operation = lbbs_pkg::OP_TICK;
                offer(it, 1'b0, none);
                n++;
                for (k = $urandom_range(0, 12); k > 0 && n < ITEMS_PER_PHASE; k--) begin
                    it.operation = lbbs_pkg::OP_TICK;
                    it.channel   = 3'($urandom_range(0, 7));
                    it.mode_code = 3'($urandom_range(0, 7));
                    offer(it, 1'b0, none);
                    n++;
                end
            end
        end

        // drain and report
        in_valid <= 1'b0;
        while (expected_patterns.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- led_buzzer_blink_sequencer.f -----
src/lbbs_pkg.sv
src/lbbs_cfg.sv
src/lbbs_chan.sv
src/led_buzzer_blink_sequencer.sv
test/testbench.sv
